@@ rtl/afcp_pkg.sv @@
// package: constants, types and helpers for the audio channel permuter
package afcp_pkg;

  localparam int MAX_CHANNELS  = 9;
  localparam int SAMPLE_WIDTH  = 64;
  localparam int TABLE_ENTRIES = 9;
  localparam int IDX_W         = $clog2(MAX_CHANNELS);
  localparam int POS_W         = $clog2(MAX_CHANNELS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES  = 2'd2;

  localparam logic [3:0]  CHANNEL_COUNT_RST = 4'd2;
  localparam logic [35:0] SLOT_TABLE_RST    = 36'h876543210;
  localparam logic [3:0]  SAMPLE_BYTES_RST  = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } afcp_state_t;

  // clamp the channel count register to 1..MAX_CHANNELS
  function automatic logic [POS_W-1:0] eff_channels(logic [3:0] cnt);
    logic [POS_W-1:0] c;
    if (cnt == 4'd0) begin
      c = POS_W'(1);
    end else if (32'(cnt) > MAX_CHANNELS) begin
      c = POS_W'(MAX_CHANNELS);
    end else begin
      c = POS_W'(cnt);
    end
    return c;
  endfunction

  // low-byte mask for the sample width register
  function automatic logic [SAMPLE_WIDTH-1:0] sample_mask(logic [3:0] nbytes);
    logic [63:0] m;
    case (nbytes)
      4'd0, 4'd1: m = 64'h0000_0000_0000_00FF;
      4'd2:       m = 64'h0000_0000_0000_FFFF;
      4'd3:       m = 64'h0000_0000_00FF_FFFF;
      4'd4:       m = 64'h0000_0000_FFFF_FFFF;
      4'd5:       m = 64'h0000_00FF_FFFF_FFFF;
      4'd6:       m = 64'h0000_FFFF_FFFF_FFFF;
      4'd7:       m = 64'h00FF_FFFF_FFFF_FFFF;
      default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m[SAMPLE_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/afcp_stream_if.sv @@
// stream interfaces for the sample input and the reordered output
interface afcp_in_if;
  import afcp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    buffer_end;

  modport source (output valid, output sample, output buffer_end, input ready);
  modport sink   (input valid, input sample, input buffer_end, output ready);
endinterface

interface afcp_out_if;
  import afcp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [SAMPLE_WIDTH-1:0] sample_out;
  logic                    last_of_run;

  modport source (output valid, output sample_out, output last_of_run, input ready);
  modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

@@ rtl/audio_frame_channel_permuter_unit.sv @@
// top level: interleaved audio channel reorder with partial-frame flush
//
//   channel  dir  beat payload
//   in_ch    in   sample[63:0], buffer_end
//   out_ch   out  sample_out[63:0], last_of_run
//   cfg_*    in   cfg_index[1:0], cfg_wdata[35:0] (write only)
//
// an input beat is stored in the memories; a beat that ends no frame leaves the unit ready
// an emitting beat then streams n results, each as a read of the slot
//   or arrival memory, then an output beat held until the sink takes it
// one item is worked on at a time; in_ch.ready is low while results drain
// synchronous reset; slot entries carry valid bits, no clearing pass
module audio_frame_channel_permuter_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [afcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afcp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  afcp_in_if.sink                          in_ch,
  afcp_out_if.source                       out_ch
);
  import afcp_pkg::*;

  logic [3:0]              channel_count_r;
  logic [35:0]             slot_table_r;
  logic [3:0]              sample_bytes_r;

  afcp_state_t             state_r, state_nxt;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        k_r;
  logic [POS_W-1:0]        n_r;
  logic                    src_arr_r;

  logic [SAMPLE_WIDTH-1:0] slot_mem [0:MAX_CHANNELS-1];
  logic [SAMPLE_WIDTH-1:0] arr_mem  [0:MAX_CHANNELS-1];
  logic [MAX_CHANNELS-1:0] slot_vld_r;
  logic [SAMPLE_WIDTH-1:0] slot_rd_r;
  logic [SAMPLE_WIDTH-1:0] arr_rd_r;
  logic                    slot_vld_rd_r;

  logic                    acc;
  logic [POS_W-1:0]        cc;
  logic [POS_W-1:0]        pos_c;
  logic [POS_W-1:0]        pos_inc;
  logic [3:0]              slot_c;
  logic                    slot_ok;
  logic                    complete;
  logic [SAMPLE_WIDTH-1:0] s_masked;
  logic [POS_W-1:0]        k_inc;
  logic                    out_beat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_count_r <= CHANNEL_COUNT_RST;
      slot_table_r    <= SLOT_TABLE_RST;
      sample_bytes_r  <= SAMPLE_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[3:0];
        CFG_SLOT_TABLE:    slot_table_r    <= cfg_wdata[35:0];
        CFG_SAMPLE_BYTES:  sample_bytes_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign acc      = in_ch.valid && in_ch.ready;
  assign cc       = eff_channels(channel_count_r);
  assign pos_c    = (32'(pos_r) >= MAX_CHANNELS) ? POS_W'(MAX_CHANNELS - 1) : pos_r;
  assign pos_inc  = pos_c + POS_W'(1);
  assign complete = (pos_inc >= cc);
  assign s_masked = in_ch.sample & sample_mask(sample_bytes_r);

  // channels past the table width use entry 0
  always_comb begin
    if (32'(pos_c) >= TABLE_ENTRIES) begin
      slot_c = slot_table_r[3:0];
    end else begin
      slot_c = slot_table_r[{pos_c[IDX_W-1:0], 2'b00} +: 4];
    end
  end
  assign slot_ok = (32'(slot_c) < MAX_CHANNELS);

  assign k_inc    = k_r + POS_W'(1);
  assign out_beat = out_ch.valid && out_ch.ready;

  // sample memories: written on an input beat, read one entry per result
  always_ff @(posedge clk) begin
    if (acc) begin
      arr_mem[pos_c[IDX_W-1:0]] <= s_masked;
      if (slot_ok) begin
        slot_mem[slot_c[IDX_W-1:0]] <= s_masked;
      end
    end
    if (state_r == ST_READ) begin
      arr_rd_r  <= arr_mem[k_r[IDX_W-1:0]];
      slot_rd_r <= slot_mem[k_r[IDX_W-1:0]];
    end
  end

  // slot entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r    <= '0;
      slot_vld_rd_r <= 1'b0;
    end else begin
      if (acc && slot_ok) begin
        slot_vld_r[slot_c[IDX_W-1:0]] <= 1'b1;
      end
      if (state_r == ST_READ) begin
        slot_vld_rd_r <= slot_vld_r[k_r[IDX_W-1:0]];
      end
    end
  end

  // frame position and result sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      k_r       <= '0;
      n_r       <= '0;
      src_arr_r <= 1'b0;
    end else begin
      if (acc) begin
        pos_r     <= (complete || in_ch.buffer_end) ? '0 : pos_inc;
        n_r       <= complete ? cc : pos_inc;
        src_arr_r <= !complete;
        k_r       <= '0;
      end else if (out_beat) begin
        k_r <= k_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (acc && (complete || in_ch.buffer_end)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          state_nxt = (k_inc == n_r) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.sample_out  = src_arr_r ? arr_rd_r :
                              (slot_vld_rd_r ? slot_rd_r : '0);
  assign out_ch.last_of_run = (k_inc == n_r);

endmodule

@@ rtl/afcp_checker.sv @@
// port-level checker for the channel permuter, bound to the top level
module afcp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // input is never taken while a result is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output valid");

  // a taken input beat is followed by a busy cycle or an idle ready
  a_no_result_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result shown right after input beat");

  // the last result of a run ends the burst
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
    else $error("output continues after last beat");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

endmodule

bind audio_frame_channel_permuter_unit afcp_checker u_afcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_of_run)
);
